### sv/assert_macros.svh
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rzn_pkg.sv
// constants, widths and types of the row z-score normalizer
package rzn_pkg;

  localparam int ROW_LEN = 6;
  localparam int SAMP_W  = 16;
  localparam int IDX_W   = $clog2(ROW_LEN);
  // n*x - sum and the running sum
  localparam int DIF_W   = SAMP_W + IDX_W + 1;
  localparam int MAG_W   = SAMP_W + IDX_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DS_W    = SQ_W + IDX_W;
  localparam int NDD_W   = SQ_W + IDX_W;
  // 4096^2 scale and the factor 4 from the odd bound
  localparam int FRAC_SH = 26;
  localparam int Q_W     = FRAC_SH + IDX_W;
  localparam int RT_W    = (Q_W + 1) / 2;
  localparam int SQ2_W   = 2 * RT_W;
  localparam int KX_W    = SAMP_W + 1;
  localparam int ALU_W   = DS_W + 1;
  localparam int CNT_W   = $clog2(Q_W);

  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(ROW_LEN - 1);
  localparam logic [SAMP_W-1:0] Z_MAX    = {1'b0, {(SAMP_W-1){1'b1}}};

  typedef struct packed {
    logic             ge;
    logic [ALU_W-1:0] diff;
  } alu_res_t;

endpackage

### sv/rzn_cmp_sub.sv
// shared compare and subtract unit for the divider and square root steps
module rzn_cmp_sub
  import rzn_pkg::*;
(
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output alu_res_t         res
);

  logic [ALU_W:0] wide;

  // borrow out of the subtraction gives the compare
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[ALU_W-1:0];
  assign res.ge   = ~wide[ALU_W];

endmodule

### sv/row_zscore_normalizer_top.sv
// row z-score normalizer: row buffer, sequencer, shared divide and root steps
// Samples load one per cycle while in the load state; the row's last sample starts the scoring pass.
// Deviation pass: difference, square and accumulate for each row element.
// Each result then takes a difference and a square, then one restoring
// divide step per cycle, then one root step per cycle, on one unit; a flat row skips both.
// Output stalls hold the sequencer in its finish state.
// rst clears the sequencer, the fill index and the result valid; no clear pass.
`include "assert_macros.svh"

module row_zscore_normalizer_top
  import rzn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic signed [SAMP_W-1:0] sample,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [SAMP_W-1:0] zscore,
  output logic                     row_end,
  output logic                     flat_row
);

  typedef enum logic [8:0] {
    ST_LOAD = 9'b000000001,
    ST_DEV  = 9'b000000010,
    ST_SQR  = 9'b000000100,
    ST_ACC  = 9'b000001000,
    ST_PREP = 9'b000010000,
    ST_DIV  = 9'b000100000,
    ST_ROOT = 9'b001000000,
    ST_SQRT = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t                   state;
  logic [IDX_W-1:0]         idx;
  logic                     scoring;
  logic [CNT_W-1:0]         it_cnt;

  logic signed [SAMP_W-1:0] row_store [ROW_LEN];
  logic signed [DIF_W-1:0]  sum;
  logic [DS_W-1:0]          dsum;
  logic [MAG_W-1:0]         mag;
  logic                     neg;
  logic [SQ_W-1:0]          dd;
  logic [DS_W-1:0]          rem;
  logic [Q_W-1:0]           dvd;
  logic [SQ2_W-1:0]         sq_src;
  logic [RT_W+1:0]          sq_rem;
  logic [RT_W-1:0]          root;
  logic                     flat;

  logic                     acc_in;
  logic                     fin_load;
  logic signed [DIF_W-1:0]  x_ext;
  logic signed [DIF_W-1:0]  d_val;
  logic [DIF_W-1:0]         d_abs;
  logic [NDD_W-1:0]         ndd;
  logic [RT_W+1:0]          sq_t;
  logic [RT_W+1:0]          sq_trial;
  logic [ALU_W-1:0]         alu_a;
  logic [ALU_W-1:0]         alu_b;
  alu_res_t                 alu;
  logic [KX_W-1:0]          k_val;
  logic [KX_W-1:0]          k_neg;
  logic [SAMP_W-1:0]        z_val;

  assign sample_stall = (state != ST_LOAD);
  assign acc_in       = sample_valid && !sample_stall;
  assign fin_load     = (state == ST_FIN) && (!result_valid || !result_stall);

  // deviation of the current element, scaled by the row length
  assign x_ext = DIF_W'(row_store[idx]);
  assign d_val = x_ext * DIF_W'(ROW_LEN) - sum;
  assign d_abs = d_val[DIF_W-1] ? DIF_W'(-d_val) : DIF_W'(d_val);
  assign ndd   = NDD_W'(dd) * NDD_W'(ROW_LEN);

  assign sq_t     = {sq_rem[RT_W-1:0], sq_src[SQ2_W-1 -: 2]};
  assign sq_trial = {root, 2'b01};

  assign alu_a = (state == ST_DIV) ? {rem, dvd[Q_W-1]} : ALU_W'(sq_t);
  assign alu_b = (state == ST_DIV) ? ALU_W'(dsum) : ALU_W'(sq_trial);

  rzn_cmp_sub u_cmp_sub (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  // largest k with (2k-1)^2 <= quotient, from the integer root
  assign k_val = (KX_W'(root) + KX_W'(1)) >> 1;
  assign k_neg = -k_val;
  always_comb begin
    if (neg) begin
      z_val = k_neg[SAMP_W-1:0];
    end else if (k_val > KX_W'(Z_MAX)) begin
      z_val = Z_MAX;
    end else begin
      z_val = k_val[SAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      idx          <= '0;
      scoring      <= 1'b0;
      it_cnt       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fin_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (acc_in) begin
            if (idx == IDX_LAST) begin
              idx     <= '0;
              scoring <= 1'b0;
              state   <= ST_DEV;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_DEV: begin
          state <= ST_SQR;
        end
        ST_SQR: begin
          state <= scoring ? ST_PREP : ST_ACC;
        end
        ST_ACC: begin
          if (idx == IDX_LAST) begin
            idx     <= '0;
            scoring <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
          state <= ST_DEV;
        end
        ST_PREP: begin
          it_cnt <= '0;
          state  <= (dsum == '0) ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          it_cnt <= it_cnt + 1'b1;
          if (it_cnt == CNT_W'(Q_W - 1)) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          it_cnt <= '0;
          state  <= ST_SQRT;
        end
        ST_SQRT: begin
          it_cnt <= it_cnt + 1'b1;
          if (it_cnt == CNT_W'(RT_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            if (idx == IDX_LAST) begin
              idx   <= '0;
              state <= ST_LOAD;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_DEV;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      zscore   <= flat ? '0 : z_val;
      row_end  <= (idx == IDX_LAST);
      flat_row <= flat;
    end
    case (state)
      ST_LOAD: begin
        if (acc_in) begin
          row_store[idx] <= sample;
          sum            <= (idx == '0) ? DIF_W'(sample) : sum + DIF_W'(sample);
          dsum           <= '0;
        end
      end
      ST_DEV: begin
        mag <= d_abs[MAG_W-1:0];
        neg <= d_val[DIF_W-1];
      end
      ST_SQR: begin
        dd <= SQ_W'(mag) * SQ_W'(mag);
      end
      ST_ACC: begin
        dsum <= dsum + DS_W'(dd);
      end
      ST_PREP: begin
        flat <= (dsum == '0);
        root <= '0;
        // dividend is n*d^2 << 26; its top part is already below the divisor
        rem  <= DS_W'(ndd[NDD_W-1:IDX_W]);
        dvd  <= {ndd[IDX_W-1:0], {FRAC_SH{1'b0}}};
      end
      ST_DIV: begin
        rem <= alu.ge ? alu.diff[DS_W-1:0] : alu_a[DS_W-1:0];
        dvd <= {dvd[Q_W-2:0], alu.ge};
      end
      ST_ROOT: begin
        sq_src <= SQ2_W'(dvd);
        sq_rem <= '0;
        root   <= '0;
      end
      ST_SQRT: begin
        sq_rem <= alu.ge ? alu.diff[RT_W+1:0] : sq_t;
        root   <= {root[RT_W-2:0], alu.ge};
        sq_src <= sq_src << 2;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_CLK(a_row_start, clk, rst, (acc_in && idx == IDX_LAST) |=> (state == ST_DEV), "full row did not start scoring")
  `ASSERT_CLK(a_div_nonzero, clk, rst, (state == ST_DIV) |-> (dsum != '0), "divide entered with zero deviation")
  `ASSERT_CLK(a_div_rem, clk, rst, (state == ST_DIV) |-> (rem < dsum), "divide remainder not below divisor")
  `ASSERT_CLK(a_flat_zero, clk, rst, (result_valid && flat_row) |-> (zscore == '0), "flat row with nonzero score")

endmodule

### tb/tb_row_zscore_normalizer_top.sv
// self-checking testbench for the row z-score normalizer: directed rows, then random rows
`timescale 1ns / 100ps

module tb_row_zscore_normalizer_top;
  import rzn_pkg::*;

  localparam int RAND_ITEMS   = 246;
  localparam int CALM_ITEMS   = 40;
  localparam int DRAIN_CYCLES = 400;
  localparam int DIRECTED_N   = 24;

  typedef enum {MODE_WIDE, MODE_JITTER, MODE_FLAT, MODE_OUTLIER, MODE_EDGES} row_mode_t;

  // typed expectation carried along with a request, used when a whole row has one
  typedef struct {
    bit                       known;
    logic signed [SAMP_W-1:0] z;
    bit                       flat;
  } row_tag_t;

  typedef struct {
    logic signed [SAMP_W-1:0] z;
    logic                     row_end;
    logic                     flat;
  } zscore_exp_t;

  logic                     clk;
  logic                     rst;
  logic                     sample_valid;
  logic                     sample_stall;
  logic signed [SAMP_W-1:0] sample;
  logic                     result_valid;
  logic                     result_stall;
  logic signed [SAMP_W-1:0] zscore;
  logic                     row_end;
  logic                     flat_row;

  row_zscore_normalizer_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .zscore       (zscore),
    .row_end      (row_end),
    .flat_row     (flat_row)
  );

  // samples with expectations typed in only for flat rows and the min/max alternation
  typedef struct {
    logic signed [SAMP_W-1:0] v;
    bit                       known;
    logic signed [SAMP_W-1:0] z;
    bit                       flat;
  } directed_t;

  directed_t directed_rows [DIRECTED_N] = '{
    '{16'sd0, 1'b1, 16'sd0, 1'b1}, '{16'sd0, 1'b1, 16'sd0, 1'b1}, '{16'sd0, 1'b1, 16'sd0, 1'b1},
    '{16'sd0, 1'b1, 16'sd0, 1'b1}, '{16'sd0, 1'b1, 16'sd0, 1'b1}, '{16'sd0, 1'b1, 16'sd0, 1'b1},
    '{16'sh7fff, 1'b1, 16'sd0, 1'b1}, '{16'sh7fff, 1'b1, 16'sd0, 1'b1},
    '{16'sh7fff, 1'b1, 16'sd0, 1'b1}, '{16'sh7fff, 1'b1, 16'sd0, 1'b1},
    '{16'sh7fff, 1'b1, 16'sd0, 1'b1}, '{16'sh7fff, 1'b1, 16'sd0, 1'b1},
    '{16'sh8000, 1'b1, 16'sd0, 1'b1}, '{16'sh8000, 1'b1, 16'sd0, 1'b1},
    '{16'sh8000, 1'b1, 16'sd0, 1'b1}, '{16'sh8000, 1'b1, 16'sd0, 1'b1},
    '{16'sh8000, 1'b1, 16'sd0, 1'b1}, '{16'sh8000, 1'b1, 16'sd0, 1'b1},
    '{16'sh8000, 1'b1, -16'sd4096, 1'b0}, '{16'sh7fff, 1'b1, 16'sd4096, 1'b0},
    '{16'sh8000, 1'b1, -16'sd4096, 1'b0}, '{16'sh7fff, 1'b1, 16'sd4096, 1'b0},
    '{16'sh8000, 1'b1, -16'sd4096, 1'b0}, '{16'sh7fff, 1'b1, 16'sd4096, 1'b0}
  };

  row_tag_t                 tag_q [$];
  zscore_exp_t              expected_z [$];
  logic signed [SAMP_W-1:0] row_buf [ROW_LEN];
  row_tag_t                 row_tags [ROW_LEN];
  int                       fill;
  int                       fails;
  int                       samples_in;
  int                       rows_scored;
  int                       flat_rows;
  int                       results_seen;
  bit                       calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still outstanding", expected_z.size());
    $display("== FAIL ==");
    $finish;
  end

  // 4096*|d|*sqrt(n/D) rounded half away from zero, found by bisection on exact integers
  function automatic logic signed [SAMP_W-1:0] scaled_dev(input longint d,
                                                          input longint unsigned dsum);
    longint unsigned mag, dd, lo, hi, mid, odd;
    bit [127:0]      lhs, rhs;
    mag = (d < 0) ? -d : d;
    dd  = mag * mag;
    lo  = 0;
    hi  = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      odd = 2 * mid - 1;
      lhs = 128'(odd * odd) * 128'(dsum);
      rhs = (128'(ROW_LEN) * 128'(dd)) << FRAC_SH;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (d < 0) return SAMP_W'(-lo);
    return (lo > 32767) ? Z_MAX : SAMP_W'(lo);
  endfunction

  task automatic take_sample(input logic signed [SAMP_W-1:0] v, input row_tag_t tag);
    longint          row_sum;
    longint          dev [ROW_LEN];
    longint unsigned dsum;
    bit              typed;
    zscore_exp_t     e;
    row_buf[fill]  = v;
    row_tags[fill] = tag;
    fill++;
    samples_in++;
    if (fill < ROW_LEN) return;
    fill    = 0;
    row_sum = 0;
    dsum    = 0;
    typed   = 1'b1;
    for (int i = 0; i < ROW_LEN; i++) begin
      row_sum += longint'(row_buf[i]);
      typed   &= row_tags[i].known;
    end
    for (int i = 0; i < ROW_LEN; i++) begin
      dev[i] = longint'(row_buf[i]) * ROW_LEN - row_sum;
      dsum  += longint'(dev[i] * dev[i]);
    end
    rows_scored++;
    if (dsum == 0) flat_rows++;
    for (int i = 0; i < ROW_LEN; i++) begin
      e.row_end = (i == ROW_LEN - 1);
      if (typed) begin
        e.z    = row_tags[i].z;
        e.flat = row_tags[i].flat;
      end else begin
        e.flat = (dsum == 0);
        e.z    = (dsum == 0) ? '0 : scaled_dev(dev[i], dsum);
      end
      expected_z.push_back(e);
    end
  endtask

  task automatic check_result();
    zscore_exp_t e;
    if (expected_z.size() == 0) begin
      $error("result with no row pending: zscore %0d row_end %0b flat_row %0b",
             zscore, row_end, flat_row);
      fails++;
      return;
    end
    e = expected_z.pop_front();
    results_seen++;
    if (zscore !== e.z) begin
      $error("zscore mismatch: expected %0d, got %0d", e.z, zscore);
      fails++;
    end
    if (row_end !== e.row_end) begin
      $error("row_end mismatch: expected %0b, got %0b", e.row_end, row_end);
      fails++;
    end
    if (flat_row !== e.flat) begin
      $error("flat_row mismatch: expected %0b, got %0b", e.flat, flat_row);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) take_sample(sample, tag_q.pop_front());
    if (!rst && result_valid && !result_stall) check_result();
  end

  // one request per call, with an optional idle burst ahead of it
  task automatic send_sample(input logic signed [SAMP_W-1:0] v, input row_tag_t tag);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    tag_q.push_back(tag);
    sample_valid <= 1'b1;
    sample       <= v;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
  endtask

  // output side: random stall bursts until the calm tail
  initial begin
    int stall_left;
    result_stall = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 8);
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    row_mode_t                mode;
    logic signed [SAMP_W-1:0] base;
    logic signed [SAMP_W-1:0] v;
    int                       odd_pos;
    row_tag_t                 tag;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    calm         = 1'b0;
    fill         = 0;
    fails        = 0;
    samples_in   = 0;
    rows_scored  = 0;
    flat_rows    = 0;
    results_seen = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIRECTED_N; n++) begin
      tag = '{directed_rows[n].known, directed_rows[n].z, directed_rows[n].flat};
      send_sample(directed_rows[n].v, tag);
    end

    tag = '{1'b0, '0, 1'b0};
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % ROW_LEN == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2: mode = MODE_WIDE;
          3, 4:    mode = MODE_JITTER;
          5:       mode = MODE_FLAT;
          6, 7:    mode = MODE_OUTLIER;
          default: mode = MODE_EDGES;
        endcase
        base    = SAMP_W'($urandom);
        odd_pos = $urandom_range(0, ROW_LEN - 1);
      end
      if (n >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      case (mode)
        MODE_JITTER:  v = base + SAMP_W'($urandom_range(0, 6)) - 16'sd3;
        MODE_FLAT:    v = base;
        MODE_OUTLIER: v = (n % ROW_LEN == odd_pos) ? SAMP_W'($urandom) : base;
        MODE_EDGES: begin
          case ($urandom_range(0, 4))
            0:       v = 16'sh8000;
            1:       v = 16'sh7fff;
            2:       v = 16'sd0;
            3:       v = -16'sd1;
            default: v = 16'sd1;
          endcase
        end
        default:      v = SAMP_W'($urandom);
      endcase
      send_sample(v, tag);
    end
    @(negedge clk);
    sample_valid <= 1'b0;

    while (expected_z.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d samples; %0d rows scored, %0d of them flat", samples_in, rows_scored,
             flat_rows);
    $display("checked %0d results with %0d mismatches", results_seen, fails);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/rzn_pkg.sv
sv/rzn_cmp_sub.sv
sv/row_zscore_normalizer_top.sv
tb/tb_row_zscore_normalizer_top.sv
